/* rtl/core/ipv4_text_range_blocklist_unit_macros.svh */
// assertion macros shared by the ipv4 blocklist rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef IPV4_TEXT_RANGE_BLOCKLIST_UNIT_MACROS_SVH
`define IPV4_TEXT_RANGE_BLOCKLIST_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define IPV4BL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define IPV4BL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ipv4bl_pkg.sv */
// shared widths, codes and control structs of the ipv4 blocklist unit
// no dependencies
`timescale 1ns / 1ps

package ipv4bl_pkg;

   localparam int FUNC_W         = 2;
   localparam int CHAR_W         = 8;
   localparam int STATUS_W       = 3;
   localparam int ADDR_W         = 32;
   localparam int ENTRIES_USED_W = 5;
   localparam int ENTRIES_DEFAULT = 16;

   // func codes; the unused code is treated as a check
   localparam logic [FUNC_W-1:0] FN_CHECK = 2'd0;
   localparam logic [FUNC_W-1:0] FN_START = 2'd1;
   localparam logic [FUNC_W-1:0] FN_END   = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NONNUM   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVER     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EXTRA    = 3'd5;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd6;
   localparam logic [STATUS_W-1:0] ST_NO_START = 3'd7;

   typedef struct packed {
      logic step;     // consume one character
      logic finish;   // close out the string
      logic clear;    // back to the start of a string
   } parse_cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] fault;
      logic [ADDR_W-1:0]   address;
   } parse_res_type;

   typedef struct packed {
      logic              store;
      logic              scan;
      logic [ADDR_W-1:0] low;
      logic [ADDR_W-1:0] high;
      logic [ADDR_W-1:0] key;
   } tbl_cmd_type;

   typedef struct packed {
      logic done;
      logic hit;
      logic full;
   } tbl_stat_type;

endpackage

/* rtl/core/ipv4bl_chan_if.sv */
// valid/ready channel interfaces for the request and response words
// depends on ipv4bl_pkg
`timescale 1ns / 1ps

interface ipv4bl_req_if import ipv4bl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [CHAR_W-1:0] char_code;
   logic              last;

   modport source (output valid, output func, output char_code, output last, input ready);
   modport sink   (input valid, input func, input char_code, input last, output ready);
endinterface

interface ipv4bl_rsp_if import ipv4bl_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic                      blocked;
   logic [ADDR_W-1:0]         address;
   logic [ENTRIES_USED_W-1:0] entries_used;

   modport source (output valid, output status, output blocked, output address,
                   output entries_used, input ready);
   modport sink   (input valid, input status, input blocked, input address,
                   input entries_used, output ready);
endinterface

/* rtl/core/ipv4bl_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ipv4bl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/ipv4bl_parser.sv */
// streaming dotted-decimal parser: one character per step, close-out on finish
// depends on ipv4bl_pkg
`timescale 1ns / 1ps

module ipv4bl_parser import ipv4bl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  parse_cmd_type     cmd,
   input  logic [CHAR_W-1:0] char_code,
   output parse_res_type     res
);

   typedef enum logic [5:0] {
      PH_START = 6'b000001,   // octet open, nothing seen
      PH_LEAD  = 6'b000010,   // whitespace only
      PH_BODY  = 6'b000100,
      PH_TRAIL = 6'b001000,
      PH_TAIL  = 6'b010000,   // after the fourth octet closes
      PH_SKIP  = 6'b100000    // after the line feed
   } phase_type;

   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'd46;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
   localparam logic [8:0]        OCTET_SAT = 9'd256;
   localparam logic [1:0]        LAST_OCTET = 2'd3;

   phase_type           phase_ff, phase_in;
   logic [1:0]          idx_ff, idx_in;
   logic [8:0]          value_ff, value_in;
   logic                flag_ff, flag_in;
   logic [STATUS_W-1:0] fault_ff, fault_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;

   logic                is_ws;
   logic                is_digit;
   logic [3:0]          digit;
   logic [11:0]         value_sum;
   logic [8:0]          value_next;
   logic                octet_blank;
   logic                octet_good;
   logic [STATUS_W-1:0] octet_fault;
   logic [STATUS_W-1:0] close_fault;
   logic [ADDR_W-1:0]   close_addr;
   phase_type           close_phase;
   logic [1:0]          close_idx;

   assign is_ws    = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
   assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign digit    = 4'(char_code - CH_ZERO);

   // value * 10 + digit, saturating at 256
   assign value_sum  = {value_ff, 3'b000} + {2'b00, value_ff, 1'b0} + 12'(digit);
   assign value_next = (value_sum > 12'(OCTET_SAT)) ? OCTET_SAT : value_sum[8:0];

   // judgment of the octet that closes now
   assign octet_blank = (phase_ff == PH_START) || (phase_ff == PH_LEAD);
   assign octet_good  = !octet_blank && !flag_ff && !value_ff[8];

   always_comb begin
      if (octet_blank) begin
         octet_fault = ST_EMPTY;
      end else if (flag_ff) begin
         octet_fault = ST_NONNUM;
      end else if (value_ff[8]) begin
         octet_fault = ST_OVER;
      end else begin
         octet_fault = ST_OK;
      end
   end

   assign close_fault = (fault_ff != ST_OK) ? fault_ff : octet_fault;
   assign close_addr  = octet_good ? {addr_ff[ADDR_W-9:0], value_ff[7:0]} : addr_ff;
   assign close_phase = (idx_ff == LAST_OCTET) ? PH_TAIL : PH_START;
   assign close_idx   = (idx_ff == LAST_OCTET) ? idx_ff : idx_ff + 2'd1;

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      value_in = value_ff;
      flag_in  = flag_ff;
      fault_in = fault_ff;
      addr_in  = addr_ff;
      if (cmd.clear) begin
         phase_in = PH_START;
         idx_in   = '0;
         value_in = '0;
         flag_in  = 1'b0;
         fault_in = ST_OK;
         addr_in  = '0;
      end else if (cmd.finish) begin
         if (phase_ff == PH_START) begin
            if (fault_ff == ST_OK) begin
               fault_in = ST_MISSING;
            end
         end else if (phase_ff == PH_LEAD || phase_ff == PH_BODY || phase_ff == PH_TRAIL) begin
            phase_in = close_phase;
            idx_in   = close_idx;
            value_in = '0;
            flag_in  = 1'b0;
            addr_in  = close_addr;
            // fewer than four octets
            if (close_fault == ST_OK && idx_ff != LAST_OCTET) begin
               fault_in = ST_MISSING;
            end else begin
               fault_in = close_fault;
            end
         end
      end else if (cmd.step) begin
         unique case (phase_ff)
            PH_TAIL: begin
               if (char_code == CH_LF) begin
                  phase_in = PH_SKIP;
               end else if (!is_ws && fault_ff == ST_OK) begin
                  fault_in = ST_EXTRA;
               end
            end
            PH_SKIP: begin
               phase_in = PH_SKIP;
            end
            default: begin
               if (char_code == CH_DOT) begin
                  phase_in = close_phase;
                  idx_in   = close_idx;
                  value_in = '0;
                  flag_in  = 1'b0;
                  fault_in = close_fault;
                  addr_in  = close_addr;
               end else if (is_ws) begin
                  if (phase_ff == PH_START) begin
                     phase_in = PH_LEAD;
                  end else if (phase_ff == PH_BODY) begin
                     phase_in = PH_TRAIL;
                  end
               end else begin
                  phase_in = PH_BODY;
                  // whitespace inside the octet, or a non-digit
                  if (phase_ff == PH_TRAIL || !is_digit) begin
                     flag_in = 1'b1;
                  end
                  if (is_digit) begin
                     value_in = value_next;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         idx_ff   <= '0;
         value_ff <= '0;
         flag_ff  <= 1'b0;
         fault_ff <= ST_OK;
         addr_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         value_ff <= value_in;
         flag_ff  <= flag_in;
         fault_ff <= fault_in;
         addr_ff  <= addr_in;
      end
   end

   assign res.fault   = fault_ff;
   assign res.address = addr_ff;

endmodule

/* rtl/core/ipv4bl_table.sv */
// range table: stores ordered pairs in a ram and scans them with one compare unit
// depends on ipv4bl_pkg, ipv4bl_ram and the assertion macro header
`timescale 1ns / 1ps
`include "ipv4_text_range_blocklist_unit_macros.svh"

module ipv4bl_table import ipv4bl_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEFAULT,
   localparam int CW = $clog2(ENTRIES + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  tbl_cmd_type   cmd,
   output tbl_stat_type  stat,
   output logic [CW-1:0] count
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   typedef enum logic [2:0] {
      T_IDLE = 3'b001,
      T_READ = 3'b010,
      T_CMP  = 3'b100
   } tstate_type;

   tstate_type          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [ADDR_W-1:0]   key_ff, key_in;
   logic [2*ADDR_W-1:0] rd_data;
   logic [ADDR_W-1:0]   rd_low;
   logic [ADDR_W-1:0]   rd_high;
   logic                hit;
   logic                at_end;
   logic                full;

   ipv4bl_ram #(
      .WIDTH (2 * ADDR_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({cmd.high, cmd.low}),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign rd_low  = rd_data[ADDR_W-1:0];
   assign rd_high = rd_data[2*ADDR_W-1:ADDR_W];
   assign hit     = (key_ff >= rd_low) && (key_ff <= rd_high);
   assign at_end  = (idx_ff + CW'(1)) == count_ff;
   assign full    = count_ff == CW'(ENTRIES);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      key_in   = key_ff;
      count_in = count_ff;
      if (cmd.store) begin
         count_in = count_ff + CW'(1);
      end
      unique case (state_ff)
         T_IDLE: begin
            if (cmd.scan) begin
               idx_in   = '0;
               key_in   = cmd.key;
               state_in = T_READ;
            end
         end
         T_READ: begin
            state_in = T_CMP;
         end
         T_CMP: begin
            if (hit || at_end) begin
               state_in = T_IDLE;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = T_READ;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
      key_ff <= key_in;
   end

   assign stat.done = (state_ff == T_CMP) && (hit || at_end);
   assign stat.hit  = (state_ff == T_CMP) && hit;
   assign stat.full = full;
   assign count     = count_ff;

   `IPV4BL_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(ENTRIES), "table count past capacity")
   `IPV4BL_ASSERT_IMP(a_scan_in_range, clock, reset, state_ff == T_CMP, idx_ff < count_ff, "scan index beyond stored ranges")
   `IPV4BL_ASSERT_IMP(a_store_idle, clock, reset, cmd.store, state_ff == T_IDLE && !full, "store during scan or when full")

endmodule

/* rtl/core/ipv4_text_range_blocklist_unit.sv */
// top level of the ipv4 text range blocklist: sequencer, pending start, result register
// depends on ipv4bl_pkg, ipv4bl_chan_if, ipv4bl_parser, ipv4bl_table, macro header
//
//   channel   | dir | word
//   ----------+-----+------------------------------------------------
//   req_chan  | in  | func, char_code, last (one text character)
//   rsp_chan  | out | status, blocked, address, entries_used
//
// a character that is not last is taken by the parser as it is accepted.
// a last character then passes close, decide and output load, plus for a check a scan
// of the stored ranges by the single compare unit (stops at the first hit).
// reset is synchronous; it empties the table count but not the range ram.
// ready drops from a last character until its result enters the output register;
// characters of the next string are accepted while that result waits.
`timescale 1ns / 1ps
`include "ipv4_text_range_blocklist_unit_macros.svh"

module ipv4_text_range_blocklist_unit import ipv4bl_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   ipv4bl_req_if.sink   req_chan,
   ipv4bl_rsp_if.source rsp_chan
);

   localparam int CW = $clog2(ENTRIES + 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_CLOSE  = 5'b00010,
      S_DECIDE = 5'b00100,
      S_SCAN   = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic                pending_valid_ff, pending_valid_in;
   logic [ADDR_W-1:0]   pending_start_ff, pending_start_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic                res_blocked_ff, res_blocked_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic                      rsp_blocked_ff, rsp_blocked_in;
   logic [ADDR_W-1:0]         rsp_addr_ff, rsp_addr_in;
   logic [ENTRIES_USED_W-1:0] rsp_used_ff, rsp_used_in;

   parse_cmd_type     parse_cmd;
   parse_res_type     parse_res;
   tbl_cmd_type       tbl_cmd;
   tbl_stat_type      tbl_stat;
   logic [CW-1:0]     entry_count;
   logic              accept;
   logic              parse_ok;
   logic [ADDR_W-1:0] parse_addr;
   logic              start_lt;
   logic              out_free;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign parse_ok       = (parse_res.fault == ST_OK);
   assign parse_addr     = parse_ok ? parse_res.address : '0;
   assign start_lt       = pending_start_ff < parse_addr;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   ipv4bl_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cmd       (parse_cmd),
      .char_code (req_chan.char_code),
      .res       (parse_res)
   );

   ipv4bl_table #(
      .ENTRIES (ENTRIES)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (tbl_cmd),
      .stat  (tbl_stat),
      .count (entry_count)
   );

   always_comb begin
      state_in         = state_ff;
      func_in          = func_ff;
      pending_valid_in = pending_valid_ff;
      pending_start_in = pending_start_ff;
      res_status_in    = res_status_ff;
      res_addr_in      = res_addr_ff;
      res_blocked_in   = res_blocked_ff;
      parse_cmd        = '0;
      tbl_cmd          = '0;
      tbl_cmd.low      = start_lt ? pending_start_ff : parse_addr;
      tbl_cmd.high     = start_lt ? parse_addr : pending_start_ff;
      tbl_cmd.key      = parse_addr;

      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_blocked_in = rsp_blocked_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_used_in    = rsp_used_ff;

      unique case (state_ff)
         S_IDLE: begin
            parse_cmd.step = accept;
            if (accept && req_chan.last) begin
               func_in  = req_chan.func;
               state_in = S_CLOSE;
            end
         end
         S_CLOSE: begin
            parse_cmd.finish = 1'b1;
            state_in         = S_DECIDE;
         end
         S_DECIDE: begin
            parse_cmd.clear = 1'b1;
            res_status_in   = parse_res.fault;
            res_addr_in     = parse_addr;
            res_blocked_in  = 1'b0;
            state_in        = S_DONE;
            unique case (func_ff)
               FN_START: begin
                  pending_valid_in = parse_ok;
                  pending_start_in = parse_addr;
               end
               FN_END: begin
                  if (parse_ok) begin
                     if (!pending_valid_ff) begin
                        res_status_in = ST_NO_START;
                     end else if (tbl_stat.full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        tbl_cmd.store = 1'b1;
                     end
                  end
                  pending_valid_in = 1'b0;
                  pending_start_in = '0;
               end
               default: begin
                  if (parse_ok && entry_count != '0) begin
                     tbl_cmd.scan = 1'b1;
                     state_in     = S_SCAN;
                  end
               end
            endcase
         end
         S_SCAN: begin
            if (tbl_stat.done) begin
               res_blocked_in = tbl_stat.hit;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_blocked_in = res_blocked_ff;
               rsp_addr_in    = res_addr_ff;
               rsp_used_in    = ENTRIES_USED_W'(entry_count);
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         pending_valid_ff <= 1'b0;
         pending_start_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         pending_valid_ff <= pending_valid_in;
         pending_start_ff <= pending_start_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      func_ff        <= func_in;
      res_status_ff  <= res_status_in;
      res_addr_ff    <= res_addr_in;
      res_blocked_ff <= res_blocked_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_blocked_ff <= rsp_blocked_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_used_ff    <= rsp_used_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.blocked      = rsp_blocked_ff;
   assign rsp_chan.address      = rsp_addr_ff;
   assign rsp_chan.entries_used = rsp_used_ff;

   `IPV4BL_ASSERT_NXT(a_last_closes, clock, reset, accept && req_chan.last, state_ff == S_CLOSE, "last word did not start close-out")
   `IPV4BL_ASSERT_IMP(a_store_needs_start, clock, reset, tbl_cmd.store, pending_valid_ff && parse_ok, "range stored without a valid start")
   `IPV4BL_ASSERT_IMP(a_blocked_only_ok, clock, reset, rsp_valid_ff && rsp_blocked_ff, rsp_status_ff == ST_OK, "blocked flagged on a faulted word")

endmodule
